@@ rtl/core/bhr_pkg.sv @@
// Shared constants and types of the Bayer highlight reconstruction core.
// Depends on nothing; the core imports it.
package bhr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 12;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = 16;
  localparam int CFG_W_W = 13;
  localparam int WCMP_W = (COL_W > CFG_W_W) ? COL_W : CFG_W_W;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int ROOT_W = (PIXEL_BITS + 2 * FRAC_BITS + 2) / 3;
  localparam int SUM_W  = ROOT_W + 3;
  localparam int MUL_A_W = (2 * ROOT_W > 16) ? 2 * ROOT_W : 16;
  localparam int MUL_B_W = (ROOT_W > 16) ? ROOT_W : 16;
  localparam int MUL_W  = MUL_A_W + MUL_B_W;
  localparam int EST_W  = 3 * ROOT_W + 1 - 2 * FRAC_BITS;
  localparam int PIX_W_MAX = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;
  localparam int THR_BASE = (PIX_W_MAX + FRAC_BITS > 32) ? PIX_W_MAX + FRAC_BITS : 32;
  localparam int THR_W  = THR_BASE + 5;
  localparam int RAM_W  = 3 * PIXEL_BITS;

  localparam logic [15:0] CLIP_RESET   = 16'd4096;
  localparam logic [15:0] RATIO_RESET  = 16'd4096;
  localparam logic [12:0] WIDTH_RESET  = 13'd4096;
  localparam logic [15:0] HEIGHT_RESET = 16'd3072;

  typedef enum logic [2:0] {
    CfgEnable = 3'd0,
    CfgClip   = 3'd1,
    CfgRed    = 3'd2,
    CfgBlue   = 3'd3,
    CfgWidth  = 3'd4,
    CfgHeight = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] prev;
    logic [PIXEL_BITS-1:0] center;
    logic [PIXEL_BITS-1:0] next;
  } win_col_t;

endpackage

@@ rtl/core/bhr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module bhr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bayer_highlight_reconstruct_core.sv @@
// Top level of the Bayer highlight reconstruction core: register port, line
// store and the per-sample sequencer. Depends on bhr_pkg and bhr_ram.
//
// Usage: RGGB samples enter in raster order on the input channel (valid and
// stall); a transfer with drain set carries no sample and pushes out the frame
// tail once every sample of the frame has arrived. Each sample leaves on the
// output channel one row plus one sample after it arrived, with frame_end on
// the last sample of the frame. The register port is APB-style, pready always
// high; write registers only while the core is idle: the core does not check.
// Sequencing: one transfer is in work at a time and the input stalls until it
// is done. A transfer with no output sample passes the line store read only;
// the last sample of a row adds the output load, a sample on the border or
// passing while disabled also evaluation (line store read, evaluation, output
// load, return to idle); other samples add the threshold test. A sample above
// its threshold then passes the square, cube and compare states for each of
// the 14 root bits of each opposed neighbour (8 for red and blue, 4 for green),
// the square state alone for each skipped window place and S_Q1, S_Q2, S_FIN
// for the final cube. The result register loads as the input stall drops.
// The output register parts the channels: a new transfer is taken while a
// result waits; a stalled receiver holds the core in its output state.
// Reset clears the counters, window and registers to their defaults; the line
// store needs no clearing.
module bayer_highlight_reconstruct_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bhr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bhr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bhr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bhr_pkg::PIXEL_BITS-1:0]   pixel_value_i,
  input  logic                             drain_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bhr_pkg::PIXEL_BITS-1:0]   pixel_out_o,
  output logic                             was_rebuilt_o,
  output logic                             frame_end_o
);
  import bhr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_THR, S_CR_SQ, S_CR_CU, S_CR_CMP,
    S_Q1, S_Q2, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {ColRed, ColGreen, ColBlue} color_e;

  state_e state_q;
  color_e color_q, color_d;

  logic                  enable_q;
  logic [15:0]           clip_q, red_q, blue_q, height_q;
  logic [CFG_W_W-1:0]    width_q;
  logic                  cfg_wr;
  cfg_idx_e              cfg_idx;

  logic [WCMP_W-1:0]     wide_w;
  logic [COL_W-1:0]      eff_w;
  logic [ROW_W-1:0]      eff_h;

  logic [COL_W-1:0]      col_q, c_d, col_n;
  logic [ROW_W-1:0]      row_q, r_d, row_n;
  logic                  restart, tail_d, ignore_d, emit_d, last_d, accept;

  logic [COL_W-1:0]      c_q;
  logic [ROW_W-1:0]      r_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  tail_q, emit_q, last_q;
  logic [1:0]            phase_q;

  win_col_t              win_q [3];
  win_col_t              rd_col, wr_col;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [RAM_W-1:0]      ram_wdata, ram_rdata;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_W-1:0]      mul_q;

  logic [1:0]            kx_q, ky_q;
  logic [ROOT_W-1:0]     root_q, bit_q, trial, root_n, q_q, q_d;
  logic [SUM_W-1:0]      sum_q;
  logic [SUM_W:0]        q_full;
  logic [PIXEL_BITS-1:0] win_sel, val_c;
  logic                  opposed, last_pos, border;
  logic [THR_W-1:0]      lhs, rhs, rhs_base;
  logic [3*ROOT_W:0]     est_full;
  logic [EST_W-1:0]      est;
  logic [EST_W+6:0]      est100;
  logic                  rebuild;

  logic [PIXEL_BITS-1:0] res_val_q;
  logic                  res_reb_q;
  logic                  out_valid_q, out_reb_q, out_end_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_free;

  function automatic logic [RAM_W-1:0] pack_word(input logic [1:0] ph, input win_col_t w);
    logic [RAM_W-1:0] r;
    r = '0;
    case (ph)
      2'd0:    r = {w.prev, w.center, w.next};
      2'd1:    r = {w.center, w.next, w.prev};
      2'd2:    r = {w.next, w.prev, w.center};
      default: r = {w.prev, w.center, w.next};
    endcase
    return r;
  endfunction

  function automatic win_col_t unpack_word(input logic [1:0] ph, input logic [RAM_W-1:0] d);
    win_col_t w;
    w = '0;
    case (ph)
      2'd0:    w = '{prev: d[RAM_W-1 -: PIXEL_BITS], center: d[2*PIXEL_BITS-1 -: PIXEL_BITS],
                     next: d[PIXEL_BITS-1:0]};
      2'd1:    w = '{center: d[RAM_W-1 -: PIXEL_BITS], next: d[2*PIXEL_BITS-1 -: PIXEL_BITS],
                     prev: d[PIXEL_BITS-1:0]};
      2'd2:    w = '{next: d[RAM_W-1 -: PIXEL_BITS], prev: d[2*PIXEL_BITS-1 -: PIXEL_BITS],
                     center: d[PIXEL_BITS-1:0]};
      default: w = '0;
    endcase
    return w;
  endfunction

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_e'(paddr[4:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      CfgEnable: prdata = APB_DATA_W'(enable_q);
      CfgClip:   prdata = APB_DATA_W'(clip_q);
      CfgRed:    prdata = APB_DATA_W'(red_q);
      CfgBlue:   prdata = APB_DATA_W'(blue_q);
      CfgWidth:  prdata = APB_DATA_W'(width_q);
      CfgHeight: prdata = APB_DATA_W'(height_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      clip_q   <= CLIP_RESET;
      red_q    <= RATIO_RESET;
      blue_q   <= RATIO_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CfgEnable: enable_q <= pwdata[0];
        CfgClip:   clip_q   <= pwdata[15:0];
        CfgRed:    red_q    <= pwdata[15:0];
        CfgBlue:   blue_q   <= pwdata[15:0];
        CfgWidth:  width_q  <= pwdata[CFG_W_W-1:0];
        CfgHeight: height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and input position bookkeeping.
  always_comb begin
    wide_w = WCMP_W'(width_q);
    if (wide_w < WCMP_W'(3)) begin
      eff_w = COL_W'(3);
    end else if (wide_w > WCMP_W'(MAX_WIDTH)) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(wide_w);
    end
    eff_h = (height_q < 16'd3) ? ROW_W'(3) : height_q;
  end

  always_comb begin
    restart  = (row_q > eff_h) || ((row_q < eff_h) && (col_q >= eff_w)) ||
               ((row_q == eff_h) && (col_q > eff_w));
    c_d      = restart ? '0 : col_q;
    r_d      = restart ? '0 : row_q;
    tail_d   = (r_d == eff_h);
    ignore_d = drain_i && !tail_d;
    emit_d   = (c_d == '0) ? (r_d >= ROW_W'(2)) : (r_d >= ROW_W'(1));
    last_d   = tail_d && (c_d == eff_w);
    col_n    = c_d;
    row_n    = r_d;
    if (!ignore_d) begin
      col_n = c_d + COL_W'(1);
      if (!tail_d && ((c_d + COL_W'(1)) >= eff_w)) begin
        col_n = '0;
        row_n = r_d + ROW_W'(1);
      end
      if (last_d) begin
        col_n = '0;
        row_n = '0;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Line store: one word per column, the three rows rotate through its slots.
  assign rd_col    = unpack_word(phase_q, ram_rdata);
  assign ram_raddr = c_d[ADDR_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = c_q[ADDR_W-1:0];
    wr_col    = '{prev: rd_col.prev, center: rd_col.center, next: pix_q};
    if (state_q == S_READ) begin
      ram_we = !tail_q;
    end else if (state_q == S_FIN) begin
      ram_we    = rebuild;
      ram_waddr = ADDR_W'(c_q - COL_W'(1));
      wr_col    = '{prev: win_q[1].prev, center: PIXEL_BITS'(est), next: win_q[1].next};
    end
    ram_wdata = pack_word(phase_q, wr_col);
  end

  bhr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Evaluation datapath.
  always_comb begin
    val_c  = win_q[1].center;
    border = (c_q < COL_W'(2)) || ((COL_W+1)'(c_q) + (COL_W+1)'(1) > (COL_W+1)'(eff_w)) ||
             (r_q < ROW_W'(2)) || ((ROW_W+1)'(r_q) + (ROW_W+1)'(1) > (ROW_W+1)'(eff_h));
    if (c_q[0] && r_q[0]) begin
      color_d = ColRed;
    end else if (!c_q[0] && !r_q[0]) begin
      color_d = ColBlue;
    end else begin
      color_d = ColGreen;
    end
    lhs      = (THR_W'(val_c) << (FRAC_BITS + 4)) + (THR_W'(val_c) << (FRAC_BITS + 2));
    rhs_base = (color_q == ColGreen) ? (THR_W'(clip_q) << FRAC_BITS) : THR_W'(mul_q[31:0]);
    rhs      = (rhs_base << 4) + (rhs_base << 1) + rhs_base;

    case (ky_q)
      2'd0:    win_sel = win_q[kx_q].prev;
      2'd1:    win_sel = win_q[kx_q].center;
      default: win_sel = win_q[kx_q].next;
    endcase
    if (color_q == ColGreen) begin
      opposed = (kx_q == 2'd1) != (ky_q == 2'd1);
    end else begin
      opposed = !((kx_q == 2'd1) && (ky_q == 2'd1));
    end
    last_pos = (kx_q == 2'd2) && (ky_q == 2'd2);
    trial    = root_q | bit_q;
    root_n   = (mul_q <= (MUL_W'(win_sel) << (2 * FRAC_BITS))) ? trial : root_q;

    if (color_q == ColGreen) begin
      q_full = ((SUM_W+1)'(sum_q) + (SUM_W+1)'(2)) >> 2;
    end else begin
      q_full = ((SUM_W+1)'(sum_q) + (SUM_W+1)'(4)) >> 3;
    end
    q_d = ROOT_W'(q_full);

    est_full = ((3*ROOT_W+1)'(mul_q[3*ROOT_W-1:0]) + ((3*ROOT_W+1)'(1) << (2*FRAC_BITS-1)))
               >> (2 * FRAC_BITS);
    est      = EST_W'(est_full);
    est100   = ((EST_W+7)'(est) << 6) + ((EST_W+7)'(est) << 5) + ((EST_W+7)'(est) << 2);
    rebuild  = (est100 > ((EST_W+7)'(1) << FRAC_BITS)) && (est < EST_W'(val_c));
  end

  // Shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EVAL: begin
        mul_a = MUL_A_W'(clip_q);
        mul_b = (color_d == ColBlue) ? MUL_B_W'(blue_q) : MUL_B_W'(red_q);
      end
      S_CR_SQ: begin
        mul_a = MUL_A_W'(trial);
        mul_b = MUL_B_W'(trial);
      end
      S_CR_CU: begin
        mul_a = MUL_A_W'(mul_q[2*ROOT_W-1:0]);
        mul_b = MUL_B_W'(trial);
      end
      S_Q1: begin
        mul_a = MUL_A_W'(q_d);
        mul_b = MUL_B_W'(q_d);
      end
      S_Q2: begin
        mul_a = MUL_A_W'(mul_q[2*ROOT_W-1:0]);
        mul_b = MUL_B_W'(q_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Sequencer, window and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      color_q     <= ColGreen;
      col_q       <= '0;
      row_q       <= '0;
      c_q         <= '0;
      r_q         <= '0;
      pix_q       <= '0;
      tail_q      <= 1'b0;
      emit_q      <= 1'b0;
      last_q      <= 1'b0;
      phase_q     <= 2'd0;
      win_q       <= '{default: '0};
      kx_q        <= '0;
      ky_q        <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      sum_q       <= '0;
      q_q         <= '0;
      res_val_q   <= '0;
      res_reb_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_reb_q   <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      if (!out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            col_q  <= col_n;
            row_q  <= row_n;
            c_q    <= c_d;
            r_q    <= r_d;
            pix_q  <= pixel_value_i;
            tail_q <= tail_d;
            emit_q <= emit_d;
            last_q <= last_d;
            if (!ignore_d) begin
              if (c_d == '0) begin
                phase_q <= (phase_q == 2'd0) ? 2'd2 : phase_q - 2'd1;
              end
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= '{prev: rd_col.prev, center: rd_col.center,
                        next: tail_q ? rd_col.next : pix_q};
          res_val_q <= win_q[2].center;
          res_reb_q <= 1'b0;
          if (!emit_q) begin
            state_q <= S_IDLE;
          end else if (c_q == '0) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_val_q <= val_c;
          color_q   <= color_d;
          state_q   <= (!enable_q || border) ? S_OUT : S_THR;
        end
        S_THR: begin
          kx_q    <= '0;
          ky_q    <= '0;
          root_q  <= '0;
          bit_q   <= ROOT_W'(1) << (ROOT_W - 1);
          sum_q   <= '0;
          state_q <= (lhs >= rhs) ? S_CR_SQ : S_OUT;
        end
        S_CR_SQ: begin
          if (opposed) begin
            state_q <= S_CR_CU;
          end else begin
            kx_q <= (kx_q == 2'd2) ? 2'd0 : kx_q + 2'd1;
            ky_q <= (kx_q == 2'd2) ? ky_q + 2'd1 : ky_q;
            if (last_pos) begin
              state_q <= S_Q1;
            end
          end
        end
        S_CR_CU: begin
          state_q <= S_CR_CMP;
        end
        S_CR_CMP: begin
          if (bit_q[0]) begin
            sum_q  <= sum_q + SUM_W'(root_n);
            root_q <= '0;
            bit_q  <= ROOT_W'(1) << (ROOT_W - 1);
            kx_q   <= (kx_q == 2'd2) ? 2'd0 : kx_q + 2'd1;
            ky_q   <= (kx_q == 2'd2) ? ky_q + 2'd1 : ky_q;
            state_q <= last_pos ? S_Q1 : S_CR_SQ;
          end else begin
            root_q  <= root_n;
            bit_q   <= bit_q >> 1;
            state_q <= S_CR_SQ;
          end
        end
        S_Q1: begin
          q_q     <= q_d;
          state_q <= S_Q2;
        end
        S_Q2: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (rebuild) begin
            win_q[1].center <= PIXEL_BITS'(est);
            res_val_q       <= PIXEL_BITS'(est);
            res_reb_q       <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= res_val_q;
            out_reb_q   <= res_reb_q;
            out_end_q   <= last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_out_o   = out_pix_q;
  assign was_rebuilt_o = out_reb_q;
  assign frame_end_o   = out_end_q;

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("line store phase out of range");

  a_root_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CR_SQ || state_q == S_CR_CU || state_q == S_CR_CMP) |-> $onehot(bit_q))
    else $error("cube root bit mask not one-hot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result left while the output register was held");

  a_last_not_rebuilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> !was_rebuilt_o)
    else $error("border sample marked as rebuilt");

  a_tail_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && tail_q) |-> !ram_we)
    else $error("line store written during frame tail");
`endif

endmodule

@@ tb/bayer_highlight_reconstruct_core_tb.sv @@
// Testbench of the Bayer highlight reconstruction core: random frames against a predictor.
// It depends on bhr_pkg and on the core bayer_highlight_reconstruct_core.
// A scoreboard class predicts each output sample and checks the output in order.

typedef struct packed {
  logic [15:0] pix;
  logic        rebuilt;
  logic        last;
} px_result_t;

typedef enum int {HueRed, HueGreen, HueBlue} hue_e;

class rebuild_scoreboard;
  bit               en;
  int unsigned      clip, red_gain, blue_gain, wreg, hreg;
  logic [15:0]      row_above[4096];
  logic [15:0]      row_mid[4096];
  logic [15:0]      row_below[4096];
  int unsigned      col_pos, row_pos;
  px_result_t       expected_q[$];
  int               errors, n_checked, n_rebuilt, n_frames;

  function new();
    en = 0;
    clip = 4096;
    red_gain = 4096;
    blue_gain = 4096;
    wreg = 4096;
    hreg = 3072;
    foreach (row_above[i]) begin
      row_above[i] = '0;
      row_mid[i] = '0;
      row_below[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    errors = 0;
    n_checked = 0;
    n_rebuilt = 0;
    n_frames = 0;
  endfunction

  function void write_reg(bhr_pkg::cfg_idx_e idx, int unsigned v);
    case (idx)
      bhr_pkg::CfgEnable: en = v[0];
      bhr_pkg::CfgClip:   clip = v & 16'hFFFF;
      bhr_pkg::CfgRed:    red_gain = v & 16'hFFFF;
      bhr_pkg::CfgBlue:   blue_gain = v & 16'hFFFF;
      bhr_pkg::CfgWidth:  wreg = v & 13'h1FFF;
      bhr_pkg::CfgHeight: hreg = v & 16'hFFFF;
      default: ;
    endcase
  endfunction

  function int unsigned width_eff();
    return (wreg < 3) ? 3 : ((wreg > 4096) ? 4096 : wreg);
  endfunction

  function int unsigned height_eff();
    return (hreg < 3) ? 3 : hreg;
  endfunction

  function hue_e hue(int unsigned x, int unsigned y);
    if (x[0] == 0 && y[0] == 0) return HueRed;
    if (x[0] == 1 && y[0] == 1) return HueBlue;
    return HueGreen;
  endfunction

  function longint unsigned cube_root(logic [15:0] v);
    longint unsigned x, r, t;
    x = longint'(v) << 24;
    r = 0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x / t) r = t;
    end
    return r;
  endfunction

  function logic [15:0] rebuild_value(int unsigned ox, int unsigned oy, int unsigned w,
                                      int unsigned h, output bit rb);
    logic [15:0]       val, v;
    longint unsigned   lhs, rhs, sum, d, q, est;
    hue_e              col;
    int unsigned       x, y;
    val = row_mid[ox];
    rb = 0;
    if (!en || ox < 1 || ox + 2 > w || oy < 1 || oy + 2 > h) return val;
    col = hue(ox, oy);
    lhs = (longint'(val) << 12) * 20;
    if (col == HueRed) rhs = longint'(clip) * red_gain * 19;
    else if (col == HueBlue) rhs = longint'(clip) * blue_gain * 19;
    else rhs = (longint'(clip) << 12) * 19;
    if (lhs < rhs) return val;
    sum = 0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        x = ox + dx - 1;
        y = oy + dy - 1;
        v = (dy == 0) ? row_above[x] : ((dy == 1) ? row_mid[x] : row_below[x]);
        if (hue(x, y) != col) sum += cube_root(v);
      end
    end
    d = (col == HueGreen) ? 4 : 8;
    q = (sum + d / 2) / d;
    est = (q * q * q + (64'd1 << 23)) >> 24;
    if (est * 100 > 4096 && est < val) begin
      row_mid[ox] = est[15:0];
      rb = 1;
      return est[15:0];
    end
    return val;
  endfunction

  // Returns 0 when the transfer was an ignored drain.
  function bit note_input(logic [15:0] p, bit dr);
    int unsigned w, h, c, r, ox, oy;
    bit          tail, emitted, rb;
    px_result_t  res;
    w = width_eff();
    h = height_eff();
    emitted = 0;
    if (row_pos > h || (row_pos < h && col_pos >= w) || (row_pos == h && col_pos > w)) begin
      row_pos = 0;
      col_pos = 0;
    end
    tail = (row_pos == h);
    if (dr && !tail) return 0;
    c = col_pos;
    r = row_pos;
    if (c == 0) begin
      if (r >= 2) begin
        ox = w - 1;
        oy = r - 2;
        res.pix = rebuild_value(ox, oy, w, h, rb);
        emitted = 1;
      end
      row_above = row_mid;
      row_mid = row_below;
      if (!tail) row_below[0] = p;
    end else begin
      if (!tail) row_below[c] = p;
      if (r >= 1) begin
        ox = c - 1;
        oy = r - 1;
        res.pix = rebuild_value(ox, oy, w, h, rb);
        emitted = 1;
      end
    end
    col_pos++;
    if (!tail && col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (emitted) begin
      res.rebuilt = rb;
      res.last = (ox == w - 1 && oy == h - 1);
      if (res.last) begin
        col_pos = 0;
        row_pos = 0;
      end
      expected_q.push_back(res);
    end
    return 1;
  endfunction

  function bit idle();
    return expected_q.size() == 0;
  endfunction

  task report(string msg);
    $display("MISMATCH %s", msg);
    errors++;
  endtask

  task check_result(logic [15:0] p, logic rb, logic fe);
    px_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected output sample %h", p));
      return;
    end
    e = expected_q.pop_front();
    n_checked++;
    if (e.rebuilt) n_rebuilt++;
    if (e.last) n_frames++;
    if (p !== e.pix) report($sformatf("pixel_out %h, expected %h", p, e.pix));
    if (rb !== e.rebuilt) report($sformatf("was_rebuilt %b, expected %b", rb, e.rebuilt));
    if (fe !== e.last) report($sformatf("frame_end %b, expected %b", fe, e.last));
  endtask
endclass

module bayer_highlight_reconstruct_core_tb;
  import bhr_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [PIXEL_BITS-1:0]   pixel_value_i = '0;
  logic                    drain_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [PIXEL_BITS-1:0]   pixel_out_o;
  logic                    was_rebuilt_o;
  logic                    frame_end_o;

  rebuild_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  int unsigned stall_mode = 0;
  int unsigned n_random = 0;

  bayer_highlight_reconstruct_core i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .pixel_value_i, .drain_i,
    .out_valid_o, .out_stall_i, .pixel_out_o, .was_rebuilt_o, .frame_end_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bayer_highlight_reconstruct_core test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(pixel_out_o, was_rebuilt_o, frame_end_o);
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task write_reg(cfg_idx_e idx, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx * 4);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task send_item(logic [15:0] p, bit dr);
    in_valid_i <= 1'b1;
    pixel_value_i <= p;
    drain_i <= dr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sb.note_input(p, dr)) n_random++;
    burst_left--;
    if (burst_left == 0) begin
      int unsigned gap;
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.idle()) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function logic [15:0] pick_pixel();
    int unsigned lo, hi;
    lo = sb.clip * 7 / 8;
    hi = (sb.clip * 3 / 2 > 65535) ? 65535 : sb.clip * 3 / 2;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(lo, hi));
      5: return 16'($urandom_range(0, 64));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Pixels of a frame with occasional ignored drains; flush_tail sends the tail, mostly drains.
  task run_pixels(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(16'($urandom_range(0, 65535)), 1'b1);
      send_item(pick_pixel(), 1'b0);
    end
  endtask

  task flush_tail();
    while (sb.row_pos != 0 || sb.col_pos != 0)
      send_item(16'($urandom_range(0, 65535)), ($urandom_range(0, 4) != 0));
  endtask

  task random_config();
    int unsigned pick;
    write_reg(CfgEnable, ($urandom_range(0, 7) != 0));
    pick = $urandom_range(0, 5);
    write_reg(CfgClip, (pick == 0) ? 0 : (pick == 1) ? 65535 : (pick == 2) ? 4096
                       : $urandom_range(1000, 20000));
    write_reg(CfgRed, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                      : $urandom_range(3000, 9000));
    write_reg(CfgBlue, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                       : $urandom_range(3000, 9000));
  endtask

  initial begin
    int unsigned w, h, frame;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, everything above threshold, extreme samples, a drain
    // inside the frame and a sample during the tail.
    write_reg(CfgEnable, 1);
    write_reg(CfgClip, 0);
    write_reg(CfgRed, 65535);
    write_reg(CfgBlue, 0);
    write_reg(CfgWidth, 2);
    write_reg(CfgHeight, 1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h1234, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    flush_tail();
    wait_idle();

    frame = 0;
    n_random = 0;
    while (n_random < 1150) begin
      if (frame % 5 == 0) random_config();
      if (frame == 3) begin
        // Largest width with the smallest height, passed through; the next
        // frame size cuts the first row short.
        write_reg(CfgEnable, 0);
        write_reg(CfgWidth, 8191);
        write_reg(CfgHeight, 0);
        run_pixels(300);
        wait_idle();
        write_reg(CfgEnable, 1);
      end else if (frame == 6) begin
        // Width shrunk mid-frame so that the position falls outside the frame.
        write_reg(CfgWidth, 8);
        write_reg(CfgHeight, 4);
        run_pixels(21);
        wait_idle();
        write_reg(CfgWidth, 4);
        send_item(pick_pixel(), 1'b0);
        wait_idle();
      end else if (frame == 9) begin
        // Tallest height, then cut below the current row.
        write_reg(CfgWidth, 3);
        write_reg(CfgHeight, 65535);
        run_pixels(12);
        wait_idle();
        write_reg(CfgHeight, 3);
        send_item(pick_pixel(), 1'b0);
        wait_idle();
      end
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      write_reg(CfgWidth, w);
      write_reg(CfgHeight, h);
      run_pixels(sb.width_eff() * sb.height_eff());
      flush_tail();
      wait_idle();
      frame++;
    end

    $display("Checked %0d output samples over %0d frames, %0d of them rebuilt.",
             sb.n_checked, sb.n_frames, sb.n_rebuilt);
    if (sb.errors == 0 && sb.idle()) begin
      $display("bayer_highlight_reconstruct_core test passed");
    end else begin
      $display("bayer_highlight_reconstruct_core test failed");
    end
    $finish;
  end
endmodule

@@ bayer_highlight_reconstruct_core.f @@
rtl/core/bhr_pkg.sv
rtl/core/bhr_ram.sv
rtl/core/bayer_highlight_reconstruct_core.sv
tb/bayer_highlight_reconstruct_core_tb.sv
